@@ design/cle_pkg.sv @@
// Shared types and constants for the C string literal escaper.
// Used by cle_front, cle_queue, cle_back and c_string_literal_escaper_core.
package cle_pkg;

  // Code unit width applied before classification (input field is 16 bits)
  localparam int CHAR_BITS = 16;
  localparam int CODE_W    = 16;
  localparam logic [CODE_W-1:0] CODE_MASK =
    (CHAR_BITS >= CODE_W) ? {CODE_W{1'b1}} : CODE_W'((64'd1 << CHAR_BITS) - 64'd1);

  // Most code units one input item can produce
  localparam int MAX_CODES = 7;
  localparam int IDX_W     = $clog2(MAX_CODES);

  // Descriptor queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Input kinds (tuser)
  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // Literal characters
  localparam logic [CODE_W-1:0] CH_QUOTE  = 16'h0022; // "
  localparam logic [CODE_W-1:0] CH_APOS   = 16'h0027; // '
  localparam logic [CODE_W-1:0] CH_LPAREN = 16'h0028; // (
  localparam logic [CODE_W-1:0] CH_RPAREN = 16'h0029; // )
  localparam logic [CODE_W-1:0] CH_ZERO   = 16'h0030; // 0
  localparam logic [CODE_W-1:0] CH_QMARK  = 16'h003F; // ?
  localparam logic [CODE_W-1:0] CH_T      = 16'h0054; // T
  localparam logic [CODE_W-1:0] CH_BSLASH = 16'h005C; // backslash
  localparam logic [CODE_W-1:0] CH_UNDER  = 16'h005F; // _
  localparam logic [CODE_W-1:0] CH_A      = 16'h0061; // a
  localparam logic [CODE_W-1:0] CH_B      = 16'h0062; // b
  localparam logic [CODE_W-1:0] CH_F      = 16'h0066; // f
  localparam logic [CODE_W-1:0] CH_N      = 16'h006E; // n
  localparam logic [CODE_W-1:0] CH_R      = 16'h0072; // r
  localparam logic [CODE_W-1:0] CH_TL     = 16'h0074; // t
  localparam logic [CODE_W-1:0] CH_V      = 16'h0076; // v

  // Control codes with a short escape
  localparam logic [4:0] CC_BEL = 5'd7;
  localparam logic [4:0] CC_BS  = 5'd8;
  localparam logic [4:0] CC_HT  = 5'd9;
  localparam logic [4:0] CC_LF  = 5'd10;
  localparam logic [4:0] CC_VT  = 5'd11;
  localparam logic [4:0] CC_FF  = 5'd12;
  localparam logic [4:0] CC_CR  = 5'd13;

  // One classified item: the code units to emit and the index of the last one
  typedef struct packed {
    logic [MAX_CODES-1:0][CODE_W-1:0] codes;
    logic [IDX_W-1:0]                 last_idx;
  } desc_t;

endpackage

@@ design/cle_front.sv @@
// Front end: accepts input transactions, tracks string state and the mode
// register, and expands each item into a code descriptor. Depends on cle_pkg.
module cle_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic                      in_tuser,
  input  logic [cle_pkg::CODE_W-1:0] in_tdata,
  input  logic                      cfg_valid,
  input  logic                      cfg_data,
  input  logic                      q_full,
  output logic                      q_push,
  output cle_pkg::desc_t            q_desc
);

  logic wrap_mode_r;
  logic started_r, started_nxt;
  logic [cle_pkg::CODE_W-1:0] ch;
  logic [cle_pkg::IDX_W-1:0]  n;
  logic [4:0]                 cc;
  logic [cle_pkg::CODE_W-1:0] esc;
  logic                       has_esc;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign ch        = in_tdata & cle_pkg::CODE_MASK;
  assign cc        = ch[4:0];

  // short escapes for control codes
  always_comb begin
    has_esc = 1'b1;
    esc     = cle_pkg::CH_N;
    unique case (cc)
      cle_pkg::CC_LF:  esc = cle_pkg::CH_N;
      cle_pkg::CC_HT:  esc = cle_pkg::CH_TL;
      cle_pkg::CC_VT:  esc = cle_pkg::CH_V;
      cle_pkg::CC_BS:  esc = cle_pkg::CH_B;
      cle_pkg::CC_CR:  esc = cle_pkg::CH_R;
      cle_pkg::CC_FF:  esc = cle_pkg::CH_F;
      cle_pkg::CC_BEL: esc = cle_pkg::CH_A;
      default:         has_esc = 1'b0;
    endcase
  end

  always_comb begin
    n            = '0;
    q_desc.codes = '0;
    started_nxt  = started_r;
    if (in_tuser == cle_pkg::ACT_END) begin
      if (!started_r) begin
        if (wrap_mode_r) begin
          q_desc.codes[n] = cle_pkg::CH_UNDER;  n = n + 1'b1;
          q_desc.codes[n] = cle_pkg::CH_T;      n = n + 1'b1;
          q_desc.codes[n] = cle_pkg::CH_LPAREN; n = n + 1'b1;
        end
        q_desc.codes[n] = cle_pkg::CH_QUOTE; n = n + 1'b1;
      end
      q_desc.codes[n] = cle_pkg::CH_QUOTE; n = n + 1'b1;
      if (wrap_mode_r) begin
        q_desc.codes[n] = cle_pkg::CH_RPAREN; n = n + 1'b1;
      end
      started_nxt = 1'b0;
    end else begin
      if (!started_r) begin
        if (wrap_mode_r) begin
          q_desc.codes[n] = cle_pkg::CH_UNDER;  n = n + 1'b1;
          q_desc.codes[n] = cle_pkg::CH_LPAREN; n = n + 1'b1;
        end
        q_desc.codes[n] = cle_pkg::CH_QUOTE; n = n + 1'b1;
        started_nxt = 1'b1;
      end
      if (ch < 16'd32) begin
        q_desc.codes[n] = cle_pkg::CH_BSLASH; n = n + 1'b1;
        if (has_esc) begin
          q_desc.codes[n] = esc; n = n + 1'b1;
        end else begin
          // three octal digits; the top digit is always zero below 32
          q_desc.codes[n] = cle_pkg::CH_ZERO; n = n + 1'b1;
          q_desc.codes[n] = cle_pkg::CH_ZERO + {14'd0, cc[4:3]}; n = n + 1'b1;
          q_desc.codes[n] = cle_pkg::CH_ZERO + {13'd0, cc[2:0]}; n = n + 1'b1;
        end
      end else if (ch == cle_pkg::CH_BSLASH || ch == cle_pkg::CH_QMARK ||
                   ch == cle_pkg::CH_APOS   || ch == cle_pkg::CH_QUOTE) begin
        q_desc.codes[n] = cle_pkg::CH_BSLASH; n = n + 1'b1;
        q_desc.codes[n] = ch;                 n = n + 1'b1;
      end else begin
        q_desc.codes[n] = ch; n = n + 1'b1;
      end
    end
    q_desc.last_idx = n - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_mode_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        wrap_mode_r <= cfg_data;
      end
      if (q_push) begin
        started_r <= started_nxt;
      end
    end
  end

endmodule

@@ design/cle_queue.sv @@
// Small descriptor FIFO decoupling the front end from the emitter.
// Depends on cle_pkg.
module cle_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cle_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output cle_pkg::desc_t head_desc
);

  cle_pkg::desc_t            mem [cle_pkg::Q_DEPTH];
  logic [cle_pkg::Q_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [cle_pkg::Q_CW-1:0]  count_r;

  assign full       = (count_r == cle_pkg::Q_CW'(cle_pkg::Q_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == cle_pkg::Q_AW'(cle_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == cle_pkg::Q_AW'(cle_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ design/cle_back.sv @@
// Emitter: walks the head descriptor one code unit per cycle, unless the output
// is stalled, into the registered output stage. Depends on cle_pkg.
module cle_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  cle_pkg::desc_t             q_desc,
  output logic                       q_pop,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [cle_pkg::CODE_W-1:0] out_tdata,
  output logic                       out_tlast
);

  logic [cle_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic                       out_valid_r;
  logic [cle_pkg::CODE_W-1:0] out_data_r;
  logic                       out_last_r;
  logic                       load, is_last;

  assign load    = q_valid && (!out_valid_r || out_tready);
  assign is_last = (idx_r == q_desc.last_idx);
  assign q_pop   = load && is_last;
  assign idx_nxt = is_last ? '0 : idx_r + 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= q_desc.codes[idx_r];
      out_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= idx_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ design/c_string_literal_escaper_core.sv @@
// Top level of the C string literal escaper: front end, descriptor queue and
// emitter. Depends on cle_pkg, cle_front, cle_queue and cle_back.
//
// Turns a stream of 16-bit code units into the text of a quoted C string
// literal, one code unit per output transaction. An input with tuser=0 carries
// one character; tuser=1 ends the string. The first character is preceded by
// an opening quote (or _(" in wrap mode); control codes get \n \t \v \b \r \f
// \a or a three-digit octal escape; backslash, ?, ' and " get a backslash;
// the end item emits the closing quote (plus ")" in wrap mode). An empty
// string gives "" or _T(""). out_tlast marks the final code unit produced by
// each input transaction. Each input yields 1 to 7 output code units; the
// emitter produces one per clock while out_tready does not stall it. The
// front end classifies a whole item in its accept cycle and parks it in a
// two-entry queue, so it keeps taking input while the emitter is busy until
// the queue is full. wrap_mode is written over the cfg channel (always
// ready) and should only change while the block is idle.
module c_string_literal_escaper_core (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_in
  input  logic        in_tuser,   // [0] action: 0 character, 1 end of string
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] code_out
  output logic        out_tlast,  // last_of_run
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // wrap_mode
);

  cle_pkg::desc_t push_desc, head_desc;
  logic           push, pop, full, head_valid;

  // register write is always accepted
  assign cfg_ready = 1'b1;

  cle_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .q_full    (full),
    .q_push    (push),
    .q_desc    (push_desc)
  );

  cle_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  cle_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (head_valid),
    .q_desc     (head_desc),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ tb/sv/tb_c_string_literal_escaper_core.sv @@
// Self-checking testbench for c_string_literal_escaper_core: directed and random strings,
// both wrap modes, random source gaps and sink stalls. Depends on cle_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_c_string_literal_escaper_core;

  // Wrap mode register values
  localparam logic WRAP_PLAIN = 1'b0;
  localparam logic WRAP_MACRO = 1'b1;

  localparam int RANDOM_ITEMS   = 250;
  localparam int HOLD_CYCLES    = 300;  // one long sink hold-off to back the core up
  localparam int WATCHDOG_LIMIT = 5000; // cycles without any transaction
  localparam int DRAIN_CYCLES   = 8;    // settle time once the last result is out

  // One pending input transaction
  typedef struct packed {
    logic                       act;
    logic [cle_pkg::CODE_W-1:0] code;
  } text_item_t;

  // One expected output code unit
  typedef struct packed {
    logic [cle_pkg::CODE_W-1:0] code;
    logic                       last;
  } code_unit_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] code_in
  logic        in_tuser = 1'b0; // [0] action: 0 character, 1 end of string
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] code_out
  logic        out_tlast;       // last_of_run
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0; // wrap_mode

  c_string_literal_escaper_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Stimulus and scoreboard storage
  text_item_t text_q[$];         // items waiting for the driver
  code_unit_t expected_units[$]; // predicted output, oldest first
  code_unit_t run_units[$];      // units of the item being predicted
  int         err_count = 0;
  int         queued_items = 0;

  // Predictor state, tracked from accepted transactions only
  logic       wrap_model = WRAP_PLAIN;
  logic       string_open = 1'b0;

  // Driver pacing
  text_item_t drive_item;
  int         burst_left = 1;
  int         gap_left = 0;

  // Sink pacing
  logic       hold_req = 1'b0;
  logic       hold_taken = 1'b0;
  int         hold_left = 0;
  int         rx_mode = 0;
  int         rx_left = 0;

  int         idle_cycles = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: expands one accepted item into its code units
  // ---------------------------------------------------------------------------
  function automatic void put_unit(input logic [cle_pkg::CODE_W-1:0] code);
    code_unit_t u;
    u.code = code;
    u.last = 1'b0;
    run_units.push_back(u);
  endfunction

  function automatic void escape_item(input logic act,
                                      input logic [cle_pkg::CODE_W-1:0] code_in);
    logic [cle_pkg::CODE_W-1:0] ch;
    logic [cle_pkg::CODE_W-1:0] esc;
    code_unit_t                 u;
    ch = code_in & cle_pkg::CODE_MASK;
    run_units.delete();
    if (act == cle_pkg::ACT_END) begin
      // end with nothing before it: empty literal in the current mode
      if (!string_open) begin
        if (wrap_model == WRAP_MACRO) begin
          put_unit(cle_pkg::CH_UNDER);
          put_unit(cle_pkg::CH_T);
          put_unit(cle_pkg::CH_LPAREN);
        end
        put_unit(cle_pkg::CH_QUOTE);
      end
      put_unit(cle_pkg::CH_QUOTE);
      if (wrap_model == WRAP_MACRO) put_unit(cle_pkg::CH_RPAREN);
      string_open = 1'b0;
    end else begin
      if (!string_open) begin
        if (wrap_model == WRAP_MACRO) begin
          put_unit(cle_pkg::CH_UNDER);
          put_unit(cle_pkg::CH_LPAREN);
        end
        put_unit(cle_pkg::CH_QUOTE);
        string_open = 1'b1;
      end
      if (ch < 32) begin
        case (ch[4:0])
          cle_pkg::CC_LF:  esc = cle_pkg::CH_N;
          cle_pkg::CC_HT:  esc = cle_pkg::CH_TL;
          cle_pkg::CC_VT:  esc = cle_pkg::CH_V;
          cle_pkg::CC_BS:  esc = cle_pkg::CH_B;
          cle_pkg::CC_CR:  esc = cle_pkg::CH_R;
          cle_pkg::CC_FF:  esc = cle_pkg::CH_F;
          cle_pkg::CC_BEL: esc = cle_pkg::CH_A;
          default:         esc = '0;
        endcase
        put_unit(cle_pkg::CH_BSLASH);
        if (esc != '0) begin
          put_unit(esc);
        end else begin
          // three-digit octal escape
          put_unit(cle_pkg::CH_ZERO + cle_pkg::CODE_W'(ch[8:6]));
          put_unit(cle_pkg::CH_ZERO + cle_pkg::CODE_W'(ch[5:3]));
          put_unit(cle_pkg::CH_ZERO + cle_pkg::CODE_W'(ch[2:0]));
        end
      end else if (ch == cle_pkg::CH_BSLASH || ch == cle_pkg::CH_QMARK ||
                   ch == cle_pkg::CH_APOS   || ch == cle_pkg::CH_QUOTE) begin
        put_unit(cle_pkg::CH_BSLASH);
        put_unit(ch);
      end else begin
        put_unit(ch);
      end
    end
    // tlast goes on the final unit of this item
    for (int i = 0; i < run_units.size(); i++) begin
      u = run_units[i];
      u.last = (i == run_units.size() - 1);
      expected_units.push_back(u);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: pops pending items, bursts of random length with random gaps.
  // in_tvalid gets at most one NBA per edge on every path.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (text_q.size() > 0) begin
        drive_item = text_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= drive_item.code;
        in_tuser  <= drive_item.act;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          // about a quarter of bursts run straight into the next one
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: stall pattern that switches between always ready, coin flip and
  // mostly stalled; one long hold-off on request, counted here.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 40);
      end
      rx_left--;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: all three channels sampled at the same edge, predictions pushed
  // before results are popped so ordering within the step does not matter.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    code_unit_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) wrap_model = cfg_data;
      if (in_tvalid && in_tready) escape_item(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_units.size() == 0) begin
          report($sformatf("unexpected code unit %h last=%b", out_tdata, out_tlast));
        end else begin
          want = expected_units.pop_front();
          if (out_tdata !== want.code)
            report($sformatf("code_out got %h want %h", out_tdata, want.code));
          if (out_tlast !== want.last)
            report($sformatf("last_of_run got %b want %b (code %h)",
                             out_tlast, want.last, want.code));
        end
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(input logic act, input logic [cle_pkg::CODE_W-1:0] code);
    text_item_t t;
    t.act  = act;
    t.code = code;
    text_q.push_back(t);
    queued_items++;
  endtask

  task automatic add_char(input logic [cle_pkg::CODE_W-1:0] code);
    add_item(cle_pkg::ACT_CHAR, code);
  endtask

  // code_in is ignored on an end, so it carries random bits
  task automatic add_end();
    add_item(cle_pkg::ACT_END, 16'($urandom));
  endtask

  function automatic logic [cle_pkg::CODE_W-1:0] random_code();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 25) return cle_pkg::CODE_W'($urandom_range(0, 31));
    if (sel < 40) begin
      case ($urandom_range(0, 3))
        0:       return cle_pkg::CH_BSLASH;
        1:       return cle_pkg::CH_QMARK;
        2:       return cle_pkg::CH_APOS;
        default: return cle_pkg::CH_QUOTE;
      endcase
    end
    if (sel < 75) return cle_pkg::CODE_W'($urandom_range(32, 126));
    return cle_pkg::CODE_W'($urandom);
  endfunction

  // Block is idle once nothing is queued, offered or outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (text_q.size() != 0 || in_tvalid || expected_units.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_wrap(input logic value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase_len;
    int str_len;
    int phase_idx;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, plain mode: empty string, every short escape, octal edges,
    // the four backslashed characters and the code unit extremes
    write_wrap(WRAP_PLAIN);
    add_end();
    add_char(16'h0000);
    add_char(16'h0007);
    add_char(16'h0008);
    add_char(16'h0009);
    add_char(16'h000A);
    add_char(16'h000B);
    add_char(16'h000C);
    add_char(16'h000D);
    add_char(16'h001F);
    add_char(16'h0020);
    add_char(cle_pkg::CH_QUOTE);
    add_char(cle_pkg::CH_APOS);
    add_char(cle_pkg::CH_QMARK);
    add_char(cle_pkg::CH_BSLASH);
    add_char(16'hFFFF);
    add_char(16'h0041);
    add_end();
    wait_idle();

    // Wrap mode: empty macro form, then a string left open across a mode change
    write_wrap(WRAP_MACRO);
    add_end();
    add_char(16'h0078);
    add_char(16'h001B);
    add_end();
    add_char(16'h0071);
    wait_idle();

    // Opened wrapped, closed plain; then opened plain, closed wrapped
    write_wrap(WRAP_PLAIN);
    add_char(16'h0072);
    add_end();
    add_char(16'h007A);
    wait_idle();
    write_wrap(WRAP_MACRO);
    add_end();
    wait_idle();

    // Random phases: mostly complete strings, some left open at the phase end
    queued_items = 0;
    phase_idx = 0;
    while (queued_items < RANDOM_ITEMS) begin
      if (phase_idx == 0)      write_wrap(WRAP_PLAIN);
      else if (phase_idx == 1) write_wrap(WRAP_MACRO);
      else                     write_wrap(1'($urandom_range(0, 1)));
      // the long sink hold-off lands in the first random phase
      if (phase_idx == 0) hold_req = 1'b1;
      phase_len = $urandom_range(30, 60);
      while (phase_len > 0) begin
        str_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 8);
        repeat (str_len) add_char(random_code());
        add_end();
        phase_len -= str_len + 1;
      end
      if ($urandom_range(0, 2) == 0) begin
        repeat ($urandom_range(1, 3)) add_char(random_code());
      end
      wait_idle();
      phase_idx++;
    end

    wait_idle();
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/cle_pkg.sv
design/cle_front.sv
design/cle_queue.sv
design/cle_back.sv
design/c_string_literal_escaper_core.sv
tb/sv/tb_c_string_literal_escaper_core.sv
